@@ rtl/core/rles_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rles_pkg
// Shared types, register indexes, codes and the colour wheel for the LED
// strip pixel serialiser.
// ----------------------------------------------------------------------------
package rles_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_EFFECT_MODE  = 3'd0;
    localparam logic [2:0] REG_STATIC_COLOR = 3'd1;
    localparam logic [2:0] REG_BRIGHTNESS   = 3'd2;
    localparam logic [2:0] REG_SPEED        = 3'd3;
    localparam logic [2:0] REG_LED_COUNT    = 3'd4;
    localparam logic [2:0] REG_RED_SLOT     = 3'd5;
    localparam logic [2:0] REG_GREEN_SLOT   = 3'd6;
    localparam logic [2:0] REG_BLUE_SLOT    = 3'd7;

    // Effect mode codes (the unused code behaves as off)
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_STATIC  = 2'd1;
    localparam logic [1:0] MODE_RAINBOW = 2'd2;

    // Default wire order when the slots are unusable: GRB
    localparam logic [1:0] SLOT_GREEN_DEF = 2'd0;
    localparam logic [1:0] SLOT_RED_DEF   = 2'd1;
    localparam logic [1:0] SLOT_BLUE_DEF  = 2'd2;

    // Symbol timing in 25 ns ticks
    localparam logic [5:0] HIGH_ONE  = 6'd32;
    localparam logic [5:0] HIGH_ZERO = 6'd16;
    localparam logic [5:0] LOW_ONE   = 6'd18;
    localparam logic [5:0] LOW_ZERO  = 6'd34;

    localparam int unsigned BITS_PER_PIXEL = 24;
    localparam logic [4:0]  LAST_BIT_IDX   = 5'(BITS_PER_PIXEL - 1);
    localparam int unsigned QUEUE_DEPTH    = 2;

    // Configuration as seen by the front and back parts
    typedef struct packed {
        logic [1:0]  effect_mode;
        logic [23:0] static_color;
        logic [7:0]  brightness;
        logic [7:0]  speed;
        logic [10:0] led_count_eff;
        logic [1:0]  red_slot;
        logic [1:0]  green_slot;
        logic [1:0]  blue_slot;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_ZERO,
        CMD_STATIC,
        CMD_WHEEL
    } cmd_kind_t;

    // Classified pixel passed from front to back
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] pos;
    } pix_cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    // 256-position colour wheel, result packed as {r, g, b}
    function automatic logic [23:0] color_wheel(input logic [7:0] pos);
        logic [7:0] p;
        logic [7:0] q;
        logic [9:0] q3;
        logic [7:0] up;
        logic [7:0] down;
        logic [23:0] rgb;
        p = 8'd255 - pos;
        if (p < 8'd85) begin
            q = p;
        end else if (p < 8'd170) begin
            q = p - 8'd85;
        end else begin
            q = p - 8'd170;
        end
        q3   = 10'(q) * 10'd3;
        up   = q3[7:0];
        down = 8'd255 - q3[7:0];
        if (p < 8'd85) begin
            rgb = {down, 8'd0, up};
        end else if (p < 8'd170) begin
            rgb = {8'd0, up, down};
        end else begin
            rgb = {up, down, 8'd0};
        end
        return rgb;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/rles_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rles_front
// Accepts pixel requests, advances the rainbow phase, classifies the pixel
// and works out the wheel position with a bit-serial divider.
// ----------------------------------------------------------------------------
module rles_front import rles_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_frame_start,
    input  wire logic [9:0] s_led_index,
    output logic            push_valid,
    output pix_cmd_t        push_cmd,
    input  wire logic       push_ready
);

    front_state_t state_reg, state_next;
    logic [15:0]  phase_reg, phase_next;
    logic [10:0]  rem_reg, rem_next;
    logic [7:0]   quo_reg, quo_next;
    logic [2:0]   step_reg, step_next;
    cmd_kind_t    kind_reg, kind_next;

    logic [11:0]  rem_shift;
    logic [11:0]  count_ext;
    logic [11:0]  rem_diff;
    logic         rem_fits;
    logic         in_range;

    // Restoring divider step: index*256 / count, one quotient bit a cycle
    assign count_ext = {1'b0, cfg.led_count_eff};
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_fits  = (rem_shift >= count_ext);
    assign rem_diff  = rem_shift - count_ext;
    assign in_range  = ({1'b0, s_led_index} < cfg.led_count_eff);

    // Handshake and command
    assign s_ready       = (state_reg == F_IDLE);
    assign push_valid    = (state_reg == F_PUSH);
    assign push_cmd.kind = kind_reg;
    assign push_cmd.pos  = phase_reg[15:8] + quo_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    if (s_frame_start) begin
                        phase_next = phase_reg + 16'({cfg.speed, 3'b000});
                    end
                    rem_next  = {1'b0, s_led_index};
                    quo_next  = '0;
                    step_next = '0;
                    priority if (in_range && cfg.effect_mode == MODE_RAINBOW) begin
                        kind_next  = CMD_WHEEL;
                        state_next = F_DIV;
                    end else if (in_range && cfg.effect_mode == MODE_STATIC) begin
                        kind_next  = CMD_STATIC;
                        state_next = F_PUSH;
                    end else begin
                        kind_next  = CMD_ZERO;
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                rem_next  = rem_fits ? rem_diff[10:0] : rem_shift[10:0];
                quo_next  = {quo_reg[6:0], rem_fits};
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Divider datapath
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        kind_reg <= kind_next;
    end

    // The partial remainder always stays below the divisor
    a_rem_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_DIV) |-> (rem_reg < cfg.led_count_eff))
        else $error("divider remainder not below count");

    // Only wheel pixels go through the divider
    a_div_is_wheel: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_DIV) |-> (kind_reg == CMD_WHEEL))
        else $error("non-wheel pixel in divider");

endmodule
`default_nettype wire

@@ rtl/core/rles_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rles_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module rles_queue import rles_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire pix_cmd_t push_cmd,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output pix_cmd_t      pop_cmd
);

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    pix_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    fill_reg, fill_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (fill_reg != CntW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CntW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

endmodule
`default_nettype wire

@@ rtl/core/rles_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rles_back
// Turns pixel commands into colour, applies brightness and wire order, and
// shifts the 24 symbols out MSB first through an output register.
// ----------------------------------------------------------------------------
module rles_back import rles_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire logic     pop_valid,
    output logic          pop_ready,
    input  wire pix_cmd_t pop_cmd,
    output logic          m_valid,
    input  wire logic     m_ready,
    output logic          m_data_bit,
    output logic [5:0]    m_high_ticks,
    output logic [5:0]    m_low_ticks,
    output logic          m_last_of_pixel
);

    // Colour stage
    logic        col_valid_reg, col_valid_next;
    logic [23:0] rgb_reg;
    logic [23:0] rgb_sel;
    logic        col_adv;

    // Scaled, ordered word stage
    logic        word_valid_reg, word_valid_next;
    logic [23:0] word_reg;
    logic [23:0] word_sel;
    logic [8:0]  scale;
    logic [16:0] r_prod, g_prod, b_prod;
    logic [7:0]  r_s, g_s, b_s;
    logic [1:0]  ri, gi, bi;
    logic        slots_ok;
    logic [7:0]  wire_byte [3];

    // Shifter and output register
    logic        sh_active_reg, sh_active_next;
    logic [23:0] sh_reg, sh_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_bit_reg, m_bit_next;
    logic        m_last_reg, m_last_next;
    logic        out_free;
    logic        load_word;
    logic        shift_step;
    logic        emit_last;

    // Handshakes between stages
    assign out_free   = !m_valid_reg || m_ready;
    assign load_word  = out_free && !sh_active_reg && word_valid_reg;
    assign shift_step = out_free && sh_active_reg;
    assign emit_last  = shift_step && (cnt_reg == LAST_BIT_IDX);
    assign col_adv    = col_valid_reg && (!word_valid_reg || load_word);
    assign pop_ready  = !col_valid_reg || col_adv;

    // Pixel colour from the command
    always_comb begin
        unique case (pop_cmd.kind)
            CMD_WHEEL:  rgb_sel = color_wheel(pop_cmd.pos);
            CMD_STATIC: rgb_sel = cfg.static_color;
            CMD_ZERO:   rgb_sel = '0;
            default:    rgb_sel = '0;
        endcase
    end

    // Brightness scale and wire order
    always_comb begin
        scale  = 9'(cfg.brightness) + 9'd1;
        r_prod = 17'(rgb_reg[23:16]) * 17'(scale);
        g_prod = 17'(rgb_reg[15:8])  * 17'(scale);
        b_prod = 17'(rgb_reg[7:0])   * 17'(scale);
        r_s    = r_prod[15:8];
        g_s    = g_prod[15:8];
        b_s    = b_prod[15:8];
        slots_ok = (cfg.red_slot <= 2'd2) && (cfg.green_slot <= 2'd2) &&
                   (cfg.blue_slot <= 2'd2) && (cfg.red_slot != cfg.green_slot) &&
                   (cfg.green_slot != cfg.blue_slot) && (cfg.red_slot != cfg.blue_slot);
        ri = slots_ok ? cfg.red_slot   : SLOT_RED_DEF;
        gi = slots_ok ? cfg.green_slot : SLOT_GREEN_DEF;
        bi = slots_ok ? cfg.blue_slot  : SLOT_BLUE_DEF;
        for (int i = 0; i < 3; i++) begin
            if (ri == 2'(i)) begin
                wire_byte[i] = r_s;
            end else if (gi == 2'(i)) begin
                wire_byte[i] = g_s;
            end else if (bi == 2'(i)) begin
                wire_byte[i] = b_s;
            end else begin
                wire_byte[i] = '0;
            end
        end
        // Wire byte 0 goes out first
        word_sel = {wire_byte[0], wire_byte[1], wire_byte[2]};
    end

    // Stage valids
    always_comb begin
        col_valid_next = col_valid_reg;
        if (col_adv) begin
            col_valid_next = 1'b0;
        end
        if (pop_valid && pop_ready) begin
            col_valid_next = 1'b1;
        end
        word_valid_next = word_valid_reg;
        if (load_word) begin
            word_valid_next = 1'b0;
        end
        if (col_adv) begin
            word_valid_next = 1'b1;
        end
    end

    // Shifter and output register
    always_comb begin
        sh_active_next = sh_active_reg;
        sh_next        = sh_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_bit_next     = m_bit_reg;
        m_last_next    = m_last_reg;
        if (load_word) begin
            m_valid_next   = 1'b1;
            m_bit_next     = word_reg[23];
            m_last_next    = 1'b0;
            sh_next        = {word_reg[22:0], 1'b0};
            cnt_next       = 5'd1;
            sh_active_next = 1'b1;
        end else if (shift_step) begin
            m_valid_next = 1'b1;
            m_bit_next   = sh_reg[23];
            m_last_next  = emit_last;
            sh_next      = {sh_reg[22:0], 1'b0};
            cnt_next     = cnt_reg + 5'd1;
            if (emit_last) begin
                sh_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_valid_reg  <= 1'b0;
            word_valid_reg <= 1'b0;
            sh_active_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            col_valid_reg  <= col_valid_next;
            word_valid_reg <= word_valid_next;
            sh_active_reg  <= sh_active_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            rgb_reg <= rgb_sel;
        end
        if (col_adv) begin
            word_reg <= word_sel;
        end
        sh_reg     <= sh_next;
        cnt_reg    <= cnt_next;
        m_bit_reg  <= m_bit_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_data_bit      = m_bit_reg;
    assign m_last_of_pixel = m_last_reg;
    assign m_high_ticks    = m_bit_reg ? HIGH_ONE : HIGH_ZERO;
    assign m_low_ticks     = m_bit_reg ? LOW_ONE : LOW_ZERO;

    // Bit counter stays within the pixel while shifting
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sh_active_reg |-> (cnt_reg >= 5'd1 && cnt_reg <= LAST_BIT_IDX))
        else $error("bit counter out of range");

    // The last symbol of a pixel ends the shift
    a_last_ends_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_last |=> (!sh_active_reg && m_valid_reg && m_last_reg))
        else $error("shifter still active after last symbol");

endmodule
`default_nettype wire

@@ rtl/core/rgb_led_effect_serializer.sv @@
`default_nettype none
// Path: front (bit-serial wheel divider for rainbow), queue, colour stage,
//   word stage, output register. The output shifter sends one symbol a
//   cycle while m_ready stays high; a new request is taken only after the
//   front has pushed the previous pixel's command into the queue.
// Reset (aresetn low, synchronous): configuration registers return to
//   their defaults, phase clears to zero, the queue and all stages empty.
// ----------------------------------------------------------------------------
// rgb_led_effect_serializer
// LED strip pixel serialiser with static and colour-wheel effects, global
// brightness and configurable wire byte order.
// ----------------------------------------------------------------------------
module rgb_led_effect_serializer import rles_pkg::*; #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata,
    // Pixel requests
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_frame_start,
    input  wire logic [9:0]  s_led_index,
    // Symbols
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_data_bit,
    output logic [5:0]       m_high_ticks,
    output logic [5:0]       m_low_ticks,
    output logic             m_last_of_pixel
);

    localparam int unsigned CountCap = (MAX_LEDS > 2047) ? 2047 : MAX_LEDS;

    logic [1:0]  effect_mode_reg;
    logic [23:0] static_color_reg;
    logic [7:0]  brightness_reg;
    logic [7:0]  speed_reg;
    logic [10:0] led_count_reg;
    logic [1:0]  red_slot_reg;
    logic [1:0]  green_slot_reg;
    logic [1:0]  blue_slot_reg;

    cfg_t        cfg;
    logic        push_valid;
    logic        push_ready;
    pix_cmd_t    push_cmd;
    logic        pop_valid;
    logic        pop_ready;
    pix_cmd_t    pop_cmd;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            effect_mode_reg  <= MODE_RAINBOW;
            static_color_reg <= 24'hFFB060;
            brightness_reg   <= 8'd40;
            speed_reg        <= 8'd50;
            led_count_reg    <= 11'd1;
            red_slot_reg     <= SLOT_RED_DEF;
            green_slot_reg   <= SLOT_GREEN_DEF;
            blue_slot_reg    <= SLOT_BLUE_DEF;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EFFECT_MODE:  effect_mode_reg  <= cfg_wdata[1:0];
                REG_STATIC_COLOR: static_color_reg <= cfg_wdata;
                REG_BRIGHTNESS:   brightness_reg   <= cfg_wdata[7:0];
                REG_SPEED:        speed_reg        <= cfg_wdata[7:0];
                REG_LED_COUNT:    led_count_reg    <= cfg_wdata[10:0];
                REG_RED_SLOT:     red_slot_reg     <= cfg_wdata[1:0];
                REG_GREEN_SLOT:   green_slot_reg   <= cfg_wdata[1:0];
                REG_BLUE_SLOT:    blue_slot_reg    <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Effective configuration, LED count clamped to the strip limit
    always_comb begin
        cfg.effect_mode   = effect_mode_reg;
        cfg.static_color  = static_color_reg;
        cfg.brightness    = brightness_reg;
        cfg.speed         = speed_reg;
        cfg.led_count_eff = (led_count_reg > 11'(CountCap)) ? 11'(CountCap) : led_count_reg;
        cfg.red_slot      = red_slot_reg;
        cfg.green_slot    = green_slot_reg;
        cfg.blue_slot     = blue_slot_reg;
    end

    rles_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_start (s_frame_start),
        .s_led_index   (s_led_index),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd),
        .push_ready    (push_ready)
    );

    rles_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    rles_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_cmd         (pop_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_bit      (m_data_bit),
        .m_high_ticks    (m_high_ticks),
        .m_low_ticks     (m_low_ticks),
        .m_last_of_pixel (m_last_of_pixel)
    );

endmodule
`default_nettype wire
